// ----- rtl/rrs_pkg.sv -----
// shared types and constants of the rounded rectangle span generator
// no dependencies; imported by every module of the block
`default_nettype none

package rrs_pkg;

    // saturation limit of the rectangle and screen dimensions
    localparam int MAX_DIM   = 2048;

    // field widths
    localparam int DIM_W     = 12;
    localparam int ROW_W     = 11;
    localparam int RAD_W     = 11;
    localparam int SROW_W    = 13;
    localparam int COLOR_W   = 32;
    localparam int DIST_W    = 10;

    // square root datapath
    localparam int PROD_W    = 24;
    localparam int ROOT_BITS = 12;
    localparam int SQRT_STEPS = 3;

    // configuration port
    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 32;

    typedef enum logic [2:0] {
        REG_LEFT,
        REG_TOP,
        REG_WIDTH,
        REG_HEIGHT,
        REG_RADIUS,
        REG_SCR_W,
        REG_SCR_H,
        REG_COLOR
    } reg_idx_t;

    // configuration with dimensions already saturated
    typedef struct packed {
        logic [DIM_W-1:0]   left;
        logic [DIM_W-1:0]   top;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [RAD_W-1:0]   radius;
        logic [DIM_W-1:0]   scr_w;
        logic [DIM_W-1:0]   scr_h;
        logic [COLOR_W-1:0] color;
    } cfg_t;

    // per item side information carried along the root pipeline
    typedef struct packed {
        logic              ok;
        logic              corner;
        logic [RAD_W-1:0]  radius;
        logic [SROW_W-1:0] sy;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/rrs_prep.sv -----
// row setup: screen row, visibility, radius clamp, corner distance and product
// depends on rrs_pkg; two register stages
`default_nettype none

module rrs_prep
    import rrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire cfg_t              cfg,
    input  wire logic              in_vld,
    input  wire logic [ROW_W-1:0]  row,
    output logic                   out_vld,
    output side_t                  out_side,
    output logic [PROD_W-1:0]      out_prod
);

    logic [DIM_W-1:0]    row_ext;
    logic [SROW_W-1:0]   sy;
    logic                ok;
    logic [DIM_W-1:0]    min_side;
    logic [RAD_W-1:0]    half;
    logic [RAD_W-1:0]    rad;
    logic                in_top;
    logic                in_bot;
    logic [DIM_W-1:0]    bot_start;
    logic [DIM_W-1:0]    dist_full;
    logic [DIST_W-1:0]   corner_dist;
    logic [DIST_W:0]     fac_a;
    logic [RAD_W+1:0]    fac_b;
    side_t               side_next;

    logic                vld_a_reg;
    side_t               side_a_reg;
    logic [DIST_W:0]     fac_a_reg;
    logic [RAD_W+1:0]    fac_b_reg;
    logic                vld_b_reg;
    side_t               side_b_reg;
    logic [PROD_W-1:0]   prod_reg;

    // screen row and row visibility
    always_comb
    begin
        row_ext = {1'b0, row};
        sy = {cfg.top[DIM_W-1], cfg.top} + {2'b00, row};
        ok = (cfg.width != '0) && (cfg.height != '0) && (row_ext < cfg.height)
            && !sy[SROW_W-1] && (sy[DIM_W-1:0] < cfg.scr_h);
    end

    // radius clamp and corner distance
    always_comb
    begin
        min_side = (cfg.width < cfg.height) ? cfg.width : cfg.height;
        half = min_side[DIM_W-1:1];
        rad = (cfg.radius > half) ? half : cfg.radius;
        bot_start = cfg.height - {1'b0, rad};
        in_top = row_ext < {1'b0, rad};
        in_bot = row_ext >= bot_start;
        dist_full = in_top ? row_ext : (cfg.height - 12'd1 - row_ext);
        corner_dist = dist_full[DIST_W-1:0];
        // factors of 4r^2 - (2r-1-2d)^2 = (2d+1)(4r-1-2d)
        fac_a = {corner_dist, 1'b1};
        fac_b = {rad, 2'b00} - 13'd1 - {2'b00, corner_dist, 1'b0};
        side_next.ok = ok;
        side_next.corner = (rad != '0) && (in_top || in_bot);
        side_next.radius = rad;
        side_next.sy = sy;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    // payload: setup stage then product stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_a_reg <= side_next;
            fac_a_reg  <= fac_a;
            fac_b_reg  <= fac_b;
            side_b_reg <= side_a_reg;
            prod_reg   <= PROD_W'(fac_a_reg) * PROD_W'(fac_b_reg);
        end
    end

    assign out_vld  = vld_b_reg;
    assign out_side = side_b_reg;
    assign out_prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/rrs_sqrt.sv -----
// pipelined integer square root, a few result bits per stage
// depends on rrs_pkg; carries side information alongside each item
`default_nettype none

module rrs_sqrt
    import rrs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_vld,
    input  wire side_t                 in_side,
    input  wire logic [PROD_W-1:0]     in_val,
    output logic                       out_vld,
    output side_t                      out_side,
    output logic [ROOT_BITS-1:0]       out_root
);

    localparam int NSTG = ROOT_BITS / SQRT_STEPS;

    logic [PROD_W-1:0] rem_reg  [NSTG];
    logic [PROD_W-1:0] res_reg  [NSTG];
    side_t             side_reg [NSTG];
    logic              vld_reg  [NSTG];

    // weight of the trial bit at a given step
    function automatic logic [PROD_W-1:0] step_bit(input int k);
        step_bit = PROD_W'(1) << (2 * (ROOT_BITS - 1 - k));
    endfunction

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stg
        logic [PROD_W-1:0] rem_in;
        logic [PROD_W-1:0] res_in;
        side_t             side_in;
        logic              vld_in;
        logic [PROD_W-1:0] rem_next;
        logic [PROD_W-1:0] res_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = in_val;
            assign res_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign res_in  = res_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        // digit recurrence steps of this stage
        always_comb
        begin
            logic [PROD_W-1:0] rem_t;
            logic [PROD_W-1:0] res_t;
            logic [PROD_W-1:0] trial;
            rem_t = rem_in;
            res_t = res_in;
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                trial = res_t + step_bit(s * SQRT_STEPS + j);
                if (rem_t >= trial)
                begin
                    rem_t = rem_t - trial;
                    res_t = (res_t >> 1) + step_bit(s * SQRT_STEPS + j);
                end
                else
                begin
                    res_t = res_t >> 1;
                end
            end
            rem_next = rem_t;
            res_next = res_t;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                res_reg[s]  <= res_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign out_side = side_reg[NSTG-1];
    assign out_root = res_reg[NSTG-1][ROOT_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/rrs_finish.sv -----
// inset, horizontal clipping and result register
// depends on rrs_pkg; output register of the block
`default_nettype none

module rrs_finish
    import rrs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire cfg_t                  cfg,
    input  wire logic                  in_vld,
    input  wire side_t                 in_side,
    input  wire logic [ROOT_BITS-1:0]  in_root,
    output logic                       out_vld,
    output logic                       span_valid,
    output logic [SROW_W-1:0]          screen_row,
    output logic [DIM_W-1:0]           span_start,
    output logic [DIM_W-1:0]           span_end,
    output logic [COLOR_W-1:0]         span_color
);

    logic [RAD_W-1:0]   inset;
    logic [DIM_W+1:0]   x_ext;
    logic [DIM_W+1:0]   left_raw;
    logic [DIM_W+1:0]   right_raw;
    logic [DIM_W-1:0]   left_clip;
    logic [DIM_W-1:0]   right_clip;
    logic               valid_next;

    logic               out_vld_reg;
    logic               span_valid_reg;
    logic [SROW_W-1:0]  screen_row_reg;
    logic [DIM_W-1:0]   span_start_reg;
    logic [DIM_W-1:0]   span_end_reg;
    logic [COLOR_W-1:0] span_color_reg;

    // corner inset and raw span ends
    always_comb
    begin
        inset = in_side.corner ? (in_side.radius - RAD_W'(in_root >> 1)) : '0;
        x_ext = {{2{cfg.left[DIM_W-1]}}, cfg.left};
        left_raw = x_ext + {3'b000, inset};
        right_raw = x_ext + {2'b00, cfg.width} - {3'b000, inset};
    end

    // clip to the screen and check for an empty span
    always_comb
    begin
        if (left_raw[DIM_W+1])
            left_clip = '0;
        else if (left_raw[DIM_W:0] > {1'b0, cfg.scr_w})
            left_clip = cfg.scr_w;
        else
            left_clip = left_raw[DIM_W-1:0];

        if (right_raw[DIM_W+1])
            right_clip = '0;
        else if (right_raw[DIM_W:0] > {1'b0, cfg.scr_w})
            right_clip = cfg.scr_w;
        else
            right_clip = right_raw[DIM_W-1:0];

        valid_next = in_side.ok && (left_clip < right_clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= in_vld;
        end
    end

    // result payload; start, end and color zeroed for rows that draw nothing
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            span_valid_reg <= valid_next;
            screen_row_reg <= in_side.sy;
            span_start_reg <= valid_next ? left_clip : '0;
            span_end_reg   <= valid_next ? right_clip : '0;
            span_color_reg <= valid_next ? cfg.color : '0;
        end
    end

    assign out_vld    = out_vld_reg;
    assign span_valid = span_valid_reg;
    assign screen_row = screen_row_reg;
    assign span_start = span_start_reg;
    assign span_end   = span_end_reg;
    assign span_color = span_color_reg;

endmodule

`default_nettype wire

// ----- rtl/rounded_rect_span_generator.sv -----
// top level of the rounded rectangle span generator: registers, stall control
// depends on rrs_pkg, rrs_prep, rrs_sqrt and rrs_finish
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     local_row
//   output    out        out_valid / out_stall   span_valid, screen_row, span_start,
//                                                span_end, span_color
//   config    in         apb write, pready = 1   paddr, pwdata, prdata
//
// one item per cycle sustained while out_stall holds no result; each item passes from acceptance to result through
// two setup and product stages, four root stages of three bits each, one clip stage
// the whole pipeline advances together; it holds only while a result waits under out_stall
// rst_n clears the valid bits and loads the register reset values
`default_nettype none

module rounded_rect_span_generator
    import rrs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_AW-1:0]     paddr,
    input  wire logic [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]          prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ROW_W-1:0]      local_row,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       span_valid,
    output logic signed [SROW_W-1:0]   screen_row,
    output logic [DIM_W-1:0]           span_start,
    output logic [DIM_W-1:0]           span_end,
    output logic [COLOR_W-1:0]         span_color
);

    logic [DIM_W-1:0]   left_reg;
    logic [DIM_W-1:0]   top_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [DIM_W-1:0]   scr_w_reg;
    logic [DIM_W-1:0]   scr_h_reg;
    logic [COLOR_W-1:0] color_reg;

    reg_idx_t           idx;
    logic               wr_en;
    cfg_t               cfg;
    logic               adv;

    logic               prep_vld;
    side_t              prep_side;
    logic [PROD_W-1:0]  prep_prod;
    logic               sqrt_vld;
    side_t              sqrt_side;
    logic [ROOT_BITS-1:0] sqrt_root;
    logic [SROW_W-1:0]  row_out;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        sat_dim = (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // register write decode
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= '0;
            scr_w_reg  <= 12'd1280;
            scr_h_reg  <= 12'd720;
            color_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LEFT:   left_reg   <= pwdata[DIM_W-1:0];
                REG_TOP:    top_reg    <= pwdata[DIM_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                REG_SCR_W:  scr_w_reg  <= pwdata[DIM_W-1:0];
                REG_SCR_H:  scr_h_reg  <= pwdata[DIM_W-1:0];
                REG_COLOR:  color_reg  <= pwdata[COLOR_W-1:0];
                default:    color_reg  <= color_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (idx)
            REG_LEFT:   prdata = CFG_DW'(left_reg);
            REG_TOP:    prdata = CFG_DW'(top_reg);
            REG_WIDTH:  prdata = CFG_DW'(width_reg);
            REG_HEIGHT: prdata = CFG_DW'(height_reg);
            REG_RADIUS: prdata = CFG_DW'(radius_reg);
            REG_SCR_W:  prdata = CFG_DW'(scr_w_reg);
            REG_SCR_H:  prdata = CFG_DW'(scr_h_reg);
            REG_COLOR:  prdata = color_reg;
            default:    prdata = '0;
        endcase
    end

    // saturated view of the configuration
    always_comb
    begin
        cfg.left   = left_reg;
        cfg.top    = top_reg;
        cfg.width  = sat_dim(width_reg);
        cfg.height = sat_dim(height_reg);
        cfg.radius = radius_reg;
        cfg.scr_w  = sat_dim(scr_w_reg);
        cfg.scr_h  = sat_dim(scr_h_reg);
        cfg.color  = color_reg;
    end

    // pipeline advances unless a finished item is held by the sink
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    rrs_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg),
        .in_vld   (in_valid),
        .row      (local_row),
        .out_vld  (prep_vld),
        .out_side (prep_side),
        .out_prod (prep_prod)
    );

    rrs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (prep_vld),
        .in_side  (prep_side),
        .in_val   (prep_prod),
        .out_vld  (sqrt_vld),
        .out_side (sqrt_side),
        .out_root (sqrt_root)
    );

    rrs_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg),
        .in_vld     (sqrt_vld),
        .in_side    (sqrt_side),
        .in_root    (sqrt_root),
        .out_vld    (out_valid),
        .span_valid (span_valid),
        .screen_row (row_out),
        .span_start (span_start),
        .span_end   (span_end),
        .span_color (span_color)
    );

    assign screen_row = $signed(row_out);

endmodule

`default_nettype wire
